### rtl/i2cram_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the i2c register access master
// no dependencies; used by i2cram_engine and i2c_register_access_master
package i2cram_pkg;

    localparam int DELAY_BITS = 16;
    localparam logic [63:0] DELAY_MAX = (64'd1 << DELAY_BITS) - 64'd1;

    // register indexes on the configuration port
    localparam logic [1:0] CFG_DEV_ADDR  = 2'd0;
    localparam logic [1:0] CFG_STEP_DLY  = 2'd1;
    localparam logic [1:0] CFG_REL_DLY   = 2'd2;
    localparam logic [1:0] CFG_POLL_LIM  = 2'd3;

    localparam logic [7:0]  RST_DEV_ADDR = 8'd0;
    localparam logic [15:0] RST_STEP_DLY = 16'd1;
    localparam logic [15:0] RST_REL_DLY  = 16'd1;
    localparam logic [7:0]  RST_POLL_LIM = 8'd101;

    typedef struct packed {
        logic [7:0]  dev_addr;
        logic [15:0] step_dly;
        logic [15:0] rel_dly;
        logic [7:0]  poll_lim;
    } t_cfg;

    typedef struct packed {
        logic [1:0] func;
        logic       is_read;
        logic [7:0] reg_addr;
        logic [7:0] byte_count;
        logic [7:0] write_byte;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        logic       scl_low;
        logic       sda_low;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       need_byte;
        logic       done_res;
        logic       nack;
        logic       busy_res;
    } t_result;

    // clamp a programmed delay to the counter width
    function automatic logic [DELAY_BITS-1:0] sat_delay(input logic [15:0] v);
        logic [63:0] vx;
        vx = {48'd0, v};
        if (vx > DELAY_MAX) begin
            sat_delay = '1;
        end else begin
            sat_delay = vx[DELAY_BITS-1:0];
        end
    endfunction

endpackage

### rtl/i2cram_engine.sv
`timescale 1ns / 1ps
// bus sequencer: one command or tick per enabled cycle, result out combinationally
// depends on i2cram_pkg
module i2cram_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  i2cram_pkg::t_item i_item,
    input  i2cram_pkg::t_cfg  i_cfg,
    output i2cram_pkg::t_result o_res
);

    localparam logic [1:0] FN_START = 2'd0;
    localparam logic [1:0] FN_WBYTE = 2'd1;
    localparam logic [1:0] FN_TICK  = 2'd2;

    localparam logic [1:0] K_ADDR_W = 2'd0;
    localparam logic [1:0] K_REG    = 2'd1;
    localparam logic [1:0] K_DATA   = 2'd2;
    localparam logic [1:0] K_ADDR_R = 2'd3;

    localparam logic [4:0] P_IDLE = 5'd0;
    localparam logic [4:0] P_ST0  = 5'd1;
    localparam logic [4:0] P_ST1  = 5'd2;
    localparam logic [4:0] P_ST2  = 5'd3;
    localparam logic [4:0] P_ST3  = 5'd4;
    localparam logic [4:0] P_ADDR = 5'd5;
    localparam logic [4:0] P_WB0  = 5'd6;
    localparam logic [4:0] P_WB1  = 5'd7;
    localparam logic [4:0] P_WB2  = 5'd8;
    localparam logic [4:0] P_AK0  = 5'd9;
    localparam logic [4:0] P_AK1  = 5'd10;
    localparam logic [4:0] P_AK2  = 5'd11;
    localparam logic [4:0] P_AKP  = 5'd12;
    localparam logic [4:0] P_NEXT = 5'd13;
    localparam logic [4:0] P_NEED = 5'd14;
    localparam logic [4:0] P_RB0  = 5'd15;
    localparam logic [4:0] P_RB1  = 5'd16;
    localparam logic [4:0] P_RB2  = 5'd17;
    localparam logic [4:0] P_RA0  = 5'd18;
    localparam logic [4:0] P_RA1  = 5'd19;
    localparam logic [4:0] P_RA2  = 5'd20;
    localparam logic [4:0] P_SP0  = 5'd21;
    localparam logic [4:0] P_SP1  = 5'd22;
    localparam logic [4:0] P_SP2  = 5'd23;
    localparam logic [4:0] P_SP3  = 5'd24;
    localparam logic [4:0] P_FIN  = 5'd25;

    localparam int DB = i2cram_pkg::DELAY_BITS;
    localparam logic [DB-1:0] DLY_ONE = {{(DB-1){1'b0}}, 1'b1};

    logic [4:0]    r_phase,  n_phase;
    logic [DB-1:0] r_delay,  n_delay;
    logic          r_pend,   n_pend;
    logic [2:0]    r_bit,    n_bit;
    logic [7:0]    r_shift,  n_shift;
    logic [7:0]    r_left,   n_left;
    logic [7:0]    r_poll,   n_poll;
    logic [7:0]    r_sreg,   n_sreg;
    logic          r_rmode,  n_rmode;
    logic          r_ponly,  n_ponly;
    logic [1:0]    r_kind,   n_kind;
    logic          r_nackf,  n_nackf;
    logic          r_scl,    n_scl;
    logic          r_sda,    n_sda;

    logic [DB-1:0] w_rel;
    logic [DB-1:0] w_step;

    assign w_rel  = i2cram_pkg::sat_delay(i_cfg.rel_dly);
    assign w_step = i2cram_pkg::sat_delay(i_cfg.step_dly);

    always_comb begin
        logic [4:0]    ph;
        logic [DB-1:0] dec;
        logic          use_r;
        logic          use_s;
        logic          do_wait;

        n_phase = r_phase;  n_delay = r_delay;  n_pend = r_pend;
        n_bit   = r_bit;    n_shift = r_shift;  n_left = r_left;
        n_poll  = r_poll;   n_sreg  = r_sreg;   n_rmode = r_rmode;
        n_ponly = r_ponly;  n_kind  = r_kind;   n_nackf = r_nackf;
        n_scl   = r_scl;    n_sda   = r_sda;
        o_res.read_byte  = 8'd0;
        o_res.read_valid = 1'b0;
        o_res.done_res   = 1'b0;
        o_res.nack       = 1'b0;
        ph      = r_phase;
        dec     = r_delay - DLY_ONE;
        use_r   = 1'b1;
        use_s   = 1'b1;
        do_wait = 1'b0;

        case (i_item.func)
            FN_START: begin
                if (r_phase == P_IDLE) begin
                    n_rmode = i_item.is_read;
                    n_sreg  = i_item.reg_addr;
                    n_left  = i_item.byte_count;
                    n_ponly = 1'b0;
                    n_nackf = 1'b0;
                    n_delay = '0;
                    n_pend  = 1'b0;
                    n_phase = P_ST0;
                end
            end
            FN_WBYTE: begin
                if (r_phase == P_NEED) begin
                    n_shift = i_item.write_byte;
                    n_kind  = K_DATA;
                    n_bit   = 3'd7;
                    n_phase = P_WB0;
                end
            end
            FN_TICK: begin
                if (r_delay != '0) begin
                    n_delay = dec;
                    if (dec == '0 && r_pend) begin
                        n_pend  = 1'b0;
                        n_delay = w_step;
                    end
                end else if (r_phase != P_IDLE) begin
                    // pass-through phases resolve first, then one line action
                    if (r_phase == P_ADDR) begin
                        n_shift = {i_cfg.dev_addr[7:1], r_ponly};
                        n_kind  = r_ponly ? K_ADDR_R : K_ADDR_W;
                        n_bit   = 3'd7;
                        ph      = P_WB0;
                    end else if (r_phase == P_NEXT) begin
                        case (r_kind)
                            K_ADDR_W: begin
                                n_shift = r_sreg;
                                n_kind  = K_REG;
                                n_bit   = 3'd7;
                                ph      = P_WB0;
                            end
                            K_REG: begin
                                if (r_rmode) begin
                                    n_ponly = 1'b1;
                                    ph      = P_ST0;
                                end else begin
                                    ph = (r_left != 8'd0) ? P_NEED : P_FIN;
                                end
                            end
                            K_DATA: begin
                                n_left = r_left - 8'd1;
                                ph     = (n_left != 8'd0) ? P_NEED : P_SP0;
                            end
                            default: begin
                                ph = (r_left != 8'd0) ? P_RB0 : P_SP0;
                            end
                        endcase
                    end
                    n_phase = ph;
                    case (ph)
                        P_ST0: begin
                            n_sda = 1'b0; do_wait = 1'b1; use_s = 1'b0; n_phase = P_ST1;
                        end
                        P_ST1: begin
                            n_scl = 1'b0; do_wait = 1'b1; n_phase = P_ST2;
                        end
                        P_ST2: begin
                            n_sda = 1'b1; do_wait = 1'b1; n_phase = P_ST3;
                        end
                        P_ST3: begin
                            n_scl = 1'b1; do_wait = 1'b1; n_phase = P_ADDR;
                        end
                        P_WB0: begin
                            n_sda = ~n_shift[n_bit]; do_wait = 1'b1; use_s = 1'b0;
                            n_phase = P_WB1;
                        end
                        P_WB1: begin
                            n_scl = 1'b0; do_wait = 1'b1; n_phase = P_WB2;
                        end
                        P_WB2: begin
                            n_scl = 1'b1; do_wait = 1'b1;
                            if (n_bit != 3'd0) begin
                                n_bit   = n_bit - 3'd1;
                                n_phase = P_WB0;
                            end else begin
                                n_phase = P_AK0;
                            end
                        end
                        P_AK0: begin
                            n_sda = 1'b1; do_wait = 1'b1; n_phase = P_AK1;
                        end
                        P_AK1: begin
                            n_scl = 1'b0; do_wait = 1'b1; n_phase = P_AK2;
                        end
                        P_AK2: begin
                            n_sda = 1'b0; do_wait = 1'b1; use_s = 1'b0;
                            n_poll = 8'd0; n_phase = P_AKP;
                        end
                        P_AKP: begin
                            do_wait = 1'b1;
                            if (i_item.sda_in) begin
                                if (r_poll >= i_cfg.poll_lim) begin
                                    // no ack within the poll limit: abort with stop
                                    n_nackf = 1'b1; n_scl = 1'b1; n_phase = P_SP0;
                                end else begin
                                    n_poll = r_poll + 8'd1; use_r = 1'b0;
                                end
                            end else begin
                                n_scl = 1'b1; n_phase = P_NEXT;
                            end
                        end
                        P_RB0: begin
                            n_sda = 1'b0; do_wait = 1'b1; use_s = 1'b0;
                            n_bit = 3'd7; n_shift = 8'd0; n_phase = P_RB1;
                        end
                        P_RB1: begin
                            n_scl = 1'b0; do_wait = 1'b1; n_phase = P_RB2;
                        end
                        P_RB2: begin
                            if (i_item.sda_in) begin
                                n_shift[n_bit] = 1'b1;
                            end
                            n_scl = 1'b1; do_wait = 1'b1;
                            if (n_bit != 3'd0) begin
                                n_bit   = n_bit - 3'd1;
                                n_phase = P_RB1;
                            end else begin
                                o_res.read_valid = 1'b1;
                                o_res.read_byte  = n_shift;
                                n_phase = P_RA0;
                            end
                        end
                        P_RA0: begin
                            n_sda = (n_left > 8'd1); do_wait = 1'b1; n_phase = P_RA1;
                        end
                        P_RA1: begin
                            n_scl = 1'b0; do_wait = 1'b1; n_phase = P_RA2;
                        end
                        P_RA2: begin
                            n_scl = 1'b1; do_wait = 1'b1; n_left = n_left - 8'd1;
                            n_phase = (n_left != 8'd0) ? P_RB0 : P_SP0;
                        end
                        P_SP0: begin
                            n_sda = 1'b1; do_wait = 1'b1; use_s = 1'b0; n_phase = P_SP1;
                        end
                        P_SP1: begin
                            n_scl = 1'b1; do_wait = 1'b1; n_phase = P_SP2;
                        end
                        P_SP2: begin
                            n_scl = 1'b0; do_wait = 1'b1; n_phase = P_SP3;
                        end
                        P_SP3: begin
                            n_sda = 1'b0; do_wait = 1'b1; n_phase = P_FIN;
                        end
                        P_FIN: begin
                            o_res.done_res = 1'b1;
                            o_res.nack     = r_nackf;
                            n_phase        = P_IDLE;
                        end
                        default: begin
                        end
                    endcase
                    // release wait first, step wait chained behind it if asked for
                    if (do_wait) begin
                        if (use_r && w_rel != '0) begin
                            n_delay = w_rel;
                            n_pend  = use_s;
                        end else begin
                            n_delay = use_s ? w_step : '0;
                            n_pend  = 1'b0;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        o_res.scl_low   = n_scl;
        o_res.sda_low   = n_sda;
        o_res.need_byte = (n_phase == P_NEED);
        o_res.busy_res  = (n_phase != P_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_delay <= '0;
            r_pend  <= 1'b0;
            r_bit   <= 3'd0;
            r_shift <= 8'd0;
            r_left  <= 8'd0;
            r_poll  <= 8'd0;
            r_sreg  <= 8'd0;
            r_rmode <= 1'b0;
            r_ponly <= 1'b0;
            r_kind  <= K_ADDR_W;
            r_nackf <= 1'b0;
            r_scl   <= 1'b0;
            r_sda   <= 1'b0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_delay <= n_delay;
            r_pend  <= n_pend;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_left  <= n_left;
            r_poll  <= n_poll;
            r_sreg  <= n_sreg;
            r_rmode <= n_rmode;
            r_ponly <= n_ponly;
            r_kind  <= n_kind;
            r_nackf <= n_nackf;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
        end
    end

endmodule

### rtl/i2c_register_access_master.sv
`timescale 1ns / 1ps
// i2c register access master: input register, bus sequencer, result register
// an accepted item goes from the input register to the result register
// throughput: one item per cycle unless stalled; sequencer state updates once per item
// reset: i_rst_n synchronous active low; lines released, sequencer idle,
//   configuration back to address 0, both delays 1, poll limit 101
// depends on i2cram_pkg and i2cram_engine
module i2c_register_access_master (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // command and tick stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // is_read[0], reg_addr[8:1], byte_count[16:9], write_byte[24:17], sda_in[25]
    input  logic [31:0] s_axis_tdata,
    // func[1:0]
    input  logic [1:0]  s_axis_tuser,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // scl_low[0], sda_low[1], read_byte[9:2], read_valid[10], need_byte[11],
    // done_res[12], nack[13], busy_res[14]
    output logic [15:0] m_axis_tdata
);

    i2cram_pkg::t_cfg    r_cfg;
    i2cram_pkg::t_item   r_in_item;
    logic                r_in_valid;
    logic                r_out_valid;
    logic [15:0]         r_out_data;
    i2cram_pkg::t_result w_res;
    logic                w_adv;
    logic                w_in_acc;

    // the item in the input register moves on when the result slot is free
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // configuration registers; user must write only while engine is quiet; unchecked
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dev_addr <= i2cram_pkg::RST_DEV_ADDR;
            r_cfg.step_dly <= i2cram_pkg::RST_STEP_DLY;
            r_cfg.rel_dly  <= i2cram_pkg::RST_REL_DLY;
            r_cfg.poll_lim <= i2cram_pkg::RST_POLL_LIM;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                i2cram_pkg::CFG_DEV_ADDR: r_cfg.dev_addr <= i_cfg_data[7:0];
                i2cram_pkg::CFG_STEP_DLY: r_cfg.step_dly <= i_cfg_data;
                i2cram_pkg::CFG_REL_DLY:  r_cfg.rel_dly  <= i_cfg_data;
                i2cram_pkg::CFG_POLL_LIM: r_cfg.poll_lim <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_item.func       <= s_axis_tuser;
            r_in_item.is_read    <= s_axis_tdata[0];
            r_in_item.reg_addr   <= s_axis_tdata[8:1];
            r_in_item.byte_count <= s_axis_tdata[16:9];
            r_in_item.write_byte <= s_axis_tdata[24:17];
            r_in_item.sda_in     <= s_axis_tdata[25];
        end
    end

    i2cram_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_item  (r_in_item),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= {1'b0, w_res.busy_res, w_res.nack, w_res.done_res,
                           w_res.need_byte, w_res.read_valid, w_res.read_byte,
                           w_res.sda_low, w_res.scl_low};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

### dv/i2c_register_access_master_tb.sv
`timescale 1ns / 1ps
// self-checking bench for i2c_register_access_master: register writes and reads driven
// as command and tick items, every result item checked against a cycle-level bus predictor
// depends on i2cram_pkg and the rtl of i2c_register_access_master
module i2c_register_access_master_tb;
    import i2cram_pkg::*;

    // item kinds carried on tuser
    localparam logic [1:0] FUNC_START  = 2'd0;
    localparam logic [1:0] FUNC_WRBYTE = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;
    localparam logic [1:0] FUNC_NOP    = 2'd3;

    // sequencer phases of the bus engine
    typedef enum logic [4:0] {
        PH_IDLE, PH_ST0, PH_ST1, PH_ST2, PH_ST3, PH_ADDR, PH_WB0, PH_WB1, PH_WB2,
        PH_AK0, PH_AK1, PH_AK2, PH_AKP, PH_NEXT, PH_NEED, PH_RB0, PH_RB1, PH_RB2,
        PH_RA0, PH_RA1, PH_RA2, PH_SP0, PH_SP1, PH_SP2, PH_SP3, PH_FIN
    } t_phase;

    // what the byte on the wire is, decides the step after its ack
    typedef enum logic [1:0] {KIND_ADDR_W, KIND_REG, KIND_DATA, KIND_ADDR_R} t_kind;

    typedef struct {
        t_item   cmd;
        t_result status;
    } t_pending;

    localparam int NO_FAIL = -1;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = CFG_DEV_ADDR;
    logic [15:0] i_cfg_data = 16'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = 32'd0;
    logic [1:0]  s_axis_tuser = FUNC_NOP;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    i2c_register_access_master DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 0;
    end

    // ------------------------------------------------------------------
    // bus engine predictor: configuration and sequencer state
    // ------------------------------------------------------------------
    logic [7:0]  cfg_dev  = RST_DEV_ADDR;
    logic [15:0] cfg_step = RST_STEP_DLY;
    logic [15:0] cfg_rel  = RST_REL_DLY;
    logic [7:0]  cfg_lim  = RST_POLL_LIM;

    t_phase      ph = PH_IDLE;
    t_kind       kind = KIND_ADDR_W;
    logic [63:0] dly = '0;
    logic        step_pend = 1'b0;
    logic [2:0]  bidx = '0;
    logic [7:0]  shreg = '0;
    logic [7:0]  left = '0;
    logic [7:0]  polls = '0;
    logic [7:0]  reg_num = '0;
    logic        rd_mode = 1'b0;
    logic        ptr_done = 1'b0;
    logic        nack_seen = 1'b0;
    logic        scl_drv = 1'b0;
    logic        sda_drv = 1'b0;

    // run statistics, counted by the stimulus helpers and the predictor
    int transfers = 0;
    int reads_started = 0;
    int bytes_read = 0;
    int nack_ends = 0;
    int clean_ends = 0;
    int work_items = 0;

    t_pending    pending_q[$];        // items waiting to be offered
    t_result     expected_status_q[$]; // predictions of accepted items, oldest first
    t_pending    in_flight;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          long_hold_left = 0;
    bit          long_hold_done = 1'b0;
    int          results_seen = 0;
    int          mismatch_cnt = 0;
    bit          quiet = 1'b0;

    // delays are clamped to the counter width of the engine
    function automatic logic [63:0] clamp_ticks(input logic [15:0] v);
        logic [63:0] wide;
        wide = {48'd0, v};
        return (wide > DELAY_MAX) ? DELAY_MAX : wide;
    endfunction

    // load the wait after a line change: release time, then optionally the step time
    task automatic arm_wait(input bit use_rel, input bit use_step);
        logic [63:0] r;
        r = clamp_ticks(cfg_rel);
        if (use_rel && r != 0) begin
            dly = r;
            step_pend = use_step;
        end else begin
            dly = use_step ? clamp_ticks(cfg_step) : 64'd0;
            step_pend = 1'b0;
        end
    endtask

    // one item through the engine: updates state, returns the status it shows
    task automatic advance_bus_engine(input t_item it, output t_result res);
        logic       got_byte;
        logic       got_done;
        logic       got_nack;
        logic [7:0] got_value;
        bit         more;
        got_byte = 1'b0;
        got_done = 1'b0;
        got_nack = 1'b0;
        got_value = 8'd0;
        case (it.func)
            FUNC_START: begin
                // a start while busy is dropped
                if (ph == PH_IDLE) begin
                    rd_mode = it.is_read;
                    reg_num = it.reg_addr;
                    left = it.byte_count;
                    ptr_done = 1'b0;
                    nack_seen = 1'b0;
                    dly = '0;
                    step_pend = 1'b0;
                    ph = PH_ST0;
                end
            end
            FUNC_WRBYTE: begin
                if (ph == PH_NEED) begin
                    shreg = it.write_byte;
                    kind = KIND_DATA;
                    bidx = 3'd7;
                    ph = PH_WB0;
                end
            end
            FUNC_TICK: begin
                if (dly != 0) begin
                    // a running wait only counts down, then the step time may follow
                    dly = dly - 1;
                    if (dly == 0 && step_pend) begin
                        step_pend = 1'b0;
                        dly = clamp_ticks(cfg_step);
                    end
                end else if (ph != PH_IDLE) begin
                    more = 1'b1;
                    while (more) begin
                        more = 1'b0;
                        case (ph)
                            PH_ST0: begin sda_drv = 1'b0; arm_wait(1, 0); ph = PH_ST1; end
                            PH_ST1: begin scl_drv = 1'b0; arm_wait(1, 1); ph = PH_ST2; end
                            PH_ST2: begin sda_drv = 1'b1; arm_wait(1, 1); ph = PH_ST3; end
                            PH_ST3: begin scl_drv = 1'b1; arm_wait(1, 1); ph = PH_ADDR; end
                            PH_ADDR: begin
                                // r/w bit replaces bit 0 of the programmed address
                                shreg = {cfg_dev[7:1], ptr_done};
                                kind = ptr_done ? KIND_ADDR_R : KIND_ADDR_W;
                                bidx = 3'd7;
                                ph = PH_WB0;
                                more = 1'b1;
                            end
                            PH_WB0: begin
                                sda_drv = ~shreg[bidx];
                                arm_wait(1, 0);
                                ph = PH_WB1;
                            end
                            PH_WB1: begin scl_drv = 1'b0; arm_wait(1, 1); ph = PH_WB2; end
                            PH_WB2: begin
                                scl_drv = 1'b1;
                                arm_wait(1, 1);
                                if (bidx != 0) begin
                                    bidx = bidx - 1;
                                    ph = PH_WB0;
                                end else begin
                                    ph = PH_AK0;
                                end
                            end
                            PH_AK0: begin sda_drv = 1'b1; arm_wait(1, 1); ph = PH_AK1; end
                            PH_AK1: begin scl_drv = 1'b0; arm_wait(1, 1); ph = PH_AK2; end
                            PH_AK2: begin
                                sda_drv = 1'b0;
                                arm_wait(1, 0);
                                polls = 8'd0;
                                ph = PH_AKP;
                            end
                            PH_AKP: begin
                                if (it.sda_in) begin
                                    // too many high polls means no ack: abort with stop
                                    if (polls >= cfg_lim) begin
                                        nack_seen = 1'b1;
                                        scl_drv = 1'b1;
                                        arm_wait(1, 1);
                                        ph = PH_SP0;
                                    end else begin
                                        polls = polls + 1;
                                        arm_wait(0, 1);
                                    end
                                end else begin
                                    scl_drv = 1'b1;
                                    arm_wait(1, 1);
                                    ph = PH_NEXT;
                                end
                            end
                            PH_NEXT: begin
                                more = 1'b1;
                                case (kind)
                                    KIND_ADDR_W: begin
                                        shreg = reg_num;
                                        kind = KIND_REG;
                                        bidx = 3'd7;
                                        ph = PH_WB0;
                                    end
                                    KIND_REG: begin
                                        if (rd_mode) begin
                                            // pointer set, go on with a repeated start
                                            ptr_done = 1'b1;
                                            ph = PH_ST0;
                                        end else if (left != 0) begin
                                            ph = PH_NEED;
                                        end else begin
                                            // write of count zero: no stop
                                            ph = PH_FIN;
                                        end
                                    end
                                    KIND_DATA: begin
                                        left = left - 1;
                                        if (left != 0) ph = PH_NEED;
                                        else ph = PH_SP0;
                                    end
                                    default: begin
                                        if (left != 0) ph = PH_RB0;
                                        else ph = PH_SP0;
                                    end
                                endcase
                            end
                            PH_RB0: begin
                                sda_drv = 1'b0;
                                arm_wait(1, 0);
                                bidx = 3'd7;
                                shreg = 8'd0;
                                ph = PH_RB1;
                            end
                            PH_RB1: begin scl_drv = 1'b0; arm_wait(1, 1); ph = PH_RB2; end
                            PH_RB2: begin
                                if (it.sda_in) shreg[bidx] = 1'b1;
                                scl_drv = 1'b1;
                                arm_wait(1, 1);
                                if (bidx != 0) begin
                                    bidx = bidx - 1;
                                    ph = PH_RB1;
                                end else begin
                                    got_byte = 1'b1;
                                    got_value = shreg;
                                    ph = PH_RA0;
                                end
                            end
                            PH_RA0: begin
                                // ack every byte but the last
                                sda_drv = (left > 8'd1);
                                arm_wait(1, 1);
                                ph = PH_RA1;
                            end
                            PH_RA1: begin scl_drv = 1'b0; arm_wait(1, 1); ph = PH_RA2; end
                            PH_RA2: begin
                                scl_drv = 1'b1;
                                arm_wait(1, 1);
                                left = left - 1;
                                if (left != 0) ph = PH_RB0;
                                else ph = PH_SP0;
                            end
                            PH_SP0: begin sda_drv = 1'b1; arm_wait(1, 0); ph = PH_SP1; end
                            PH_SP1: begin scl_drv = 1'b1; arm_wait(1, 1); ph = PH_SP2; end
                            PH_SP2: begin scl_drv = 1'b0; arm_wait(1, 1); ph = PH_SP3; end
                            PH_SP3: begin sda_drv = 1'b0; arm_wait(1, 1); ph = PH_FIN; end
                            PH_FIN: begin
                                got_done = 1'b1;
                                got_nack = nack_seen;
                                ph = PH_IDLE;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            default: ;
        endcase
        if (got_byte) bytes_read++;
        if (got_done && got_nack) nack_ends++;
        if (got_done && !got_nack) clean_ends++;
        res.scl_low    = scl_drv;
        res.sda_low    = sda_drv;
        res.read_byte  = got_value;
        res.read_valid = got_byte;
        res.need_byte  = (ph == PH_NEED);
        res.done_res   = got_done;
        res.nack       = got_nack;
        res.busy_res   = (ph != PH_IDLE);
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(input logic [1:0] func, input logic rd, input logic [7:0] reg_no,
                             input logic [7:0] count, input logic [7:0] data, input logic sda);
        t_pending p;
        bit       ignored;
        p.cmd.func = func;
        p.cmd.is_read = rd;
        p.cmd.reg_addr = reg_no;
        p.cmd.byte_count = count;
        p.cmd.write_byte = data;
        p.cmd.sda_in = sda;
        ignored = (func == FUNC_NOP) || (func == FUNC_START && ph != PH_IDLE) ||
                  (func == FUNC_WRBYTE && ph != PH_NEED) ||
                  (func == FUNC_TICK && ph == PH_IDLE && dly == 0);
        if (!ignored) work_items++;
        advance_bus_engine(p.cmd, p.status);
        pending_q.push_back(p);
    endtask

    // an item the engine should drop in its current phase
    task automatic push_noise();
        int pick;
        pick = $urandom_range(0, 2);
        if (pick == 0 && ph != PH_IDLE) begin
            push_item(FUNC_START, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else if (pick == 1 && ph != PH_NEED) begin
            push_item(FUNC_WRBYTE, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
            push_item(FUNC_NOP, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    // sender waits until every accepted item has its result back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_q.size() != 0 || s_axis_tvalid || expected_status_q.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
    endtask

    // reprogram all four registers once the engine has gone quiet
    task automatic program_regs(input logic [7:0] dev, input logic [15:0] step_t,
                                input logic [15:0] rel_t, input logic [7:0] lim);
        wait_drained();
        repeat (3) @(posedge i_clk);
        write_reg(CFG_DEV_ADDR, {8'd0, dev});
        write_reg(CFG_STEP_DLY, step_t);
        write_reg(CFG_REL_DLY, rel_t);
        write_reg(CFG_POLL_LIM, {8'd0, lim});
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_dev = dev;
        cfg_step = step_t;
        cfg_rel = rel_t;
        cfg_lim = lim;
        @(negedge i_clk);
    endtask

    task automatic push_start(input bit rd, input logic [7:0] reg_no, input logic [7:0] count);
        transfers++;
        if (rd) reads_started++;
        push_item(FUNC_START, rd, reg_no, count, $urandom, $urandom);
    endtask

    // tick the engine until the transfer ends; the device acks every byte but the one
    // numbered fail_ack, and sometimes keeps sda high for a few polls within the limit
    task automatic finish_transfer(input int fail_ack, input bit edge_data, input bit pause_mid);
        int         acks_done;
        int         steps;
        int         data_no;
        logic       sda;
        logic [7:0] data;
        acks_done = 0;
        steps = 0;
        data_no = 0;
        while (ph != PH_IDLE) begin
            steps++;
            if (pause_mid && steps == 40) wait_drained();
            if ($urandom_range(0, 29) == 0) push_noise();
            if (ph == PH_NEED) begin
                data = edge_data ? (data_no[0] ? 8'hFF : 8'h00) : 8'($urandom);
                data_no++;
                // a tick while waiting for data does nothing
                if ($urandom_range(0, 3) == 0)
                    push_item(FUNC_TICK, $urandom, $urandom, $urandom, $urandom, $urandom);
                push_item(FUNC_WRBYTE, $urandom, $urandom, $urandom, data, $urandom);
            end else begin
                sda = $urandom_range(0, 1);
                if (ph == PH_AKP && dly == 0) begin
                    if (acks_done == fail_ack) begin
                        sda = 1'b1;
                    end else if (polls < cfg_lim && $urandom_range(0, 3) == 0) begin
                        sda = 1'b1;
                    end else begin
                        sda = 1'b0;
                        acks_done++;
                    end
                end
                push_item(FUNC_TICK, $urandom, $urandom, $urandom, $urandom, sda);
            end
        end
    endtask

    // mostly short transfers; rare long counts end early on a missing ack
    task automatic random_transfer(input bit pause_mid);
        bit rd;
        int r;
        int cnt;
        int fail;
        rd = $urandom_range(0, 1);
        r = $urandom_range(0, 19);
        if (r == 0) begin
            cnt = $urandom_range(128, 255);
            fail = $urandom_range(0, rd ? 2 : 1);
        end else begin
            cnt = (r < 14) ? $urandom_range(0, 3) : $urandom_range(4, 8);
            fail = ($urandom_range(0, 5) == 0) ? $urandom_range(0, rd ? 2 : cnt + 1) : NO_FAIL;
        end
        if ($urandom_range(0, 5) == 0) push_noise();
        push_start(rd, $urandom, cnt);
        finish_transfer(fail, 1'b0, pause_mid);
    endtask

    task automatic run_phase(input logic [7:0] dev, input logic [15:0] step_t,
                             input logic [15:0] rel_t, input logic [7:0] lim,
                             input int quota, input bit pause_first);
        int base;
        bit first;
        program_regs(dev, step_t, rel_t, lim);
        base = work_items;
        first = 1'b1;
        while (work_items - base < quota) begin
            random_transfer(pause_first && first);
            first = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // driver: offers queued items, one per handshake
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) expected_status_q.push_back(in_flight.status);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap == 0 && !quiet && $urandom_range(0, 9) == 0)
                    send_gap = $urandom_range(1, 18);
                if (send_gap != 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    in_flight = pending_q.pop_front();
                    s_axis_tdata <= {6'd0, in_flight.cmd.sda_in, in_flight.cmd.write_byte,
                                     in_flight.cmd.byte_count, in_flight.cmd.reg_addr,
                                     in_flight.cmd.is_read};
                    s_axis_tuser <= in_flight.cmd.func;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, once, while the sender still offers items
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            long_hold_left <= 0;
        end else if (long_hold_left != 0) begin
            long_hold_left <= long_hold_left - 1;
        end else if (!long_hold_done && results_seen >= 700 && s_axis_tvalid) begin
            long_hold_left <= 400;
            long_hold_done <= 1'b1;
        end
    end

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            mismatch_cnt++;
        end
    endtask

    // ------------------------------------------------------------------
    // monitor: takes result items and checks them in order
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : collect
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen <= results_seen + 1;
                got.scl_low    = m_axis_tdata[0];
                got.sda_low    = m_axis_tdata[1];
                got.read_byte  = m_axis_tdata[9:2];
                got.read_valid = m_axis_tdata[10];
                got.need_byte  = m_axis_tdata[11];
                got.done_res   = m_axis_tdata[12];
                got.nack       = m_axis_tdata[13];
                got.busy_res   = m_axis_tdata[14];
                if (expected_status_q.size() == 0) begin
                    $error("result item arrived with nothing expected: %h", m_axis_tdata);
                    mismatch_cnt++;
                end else begin
                    want = expected_status_q.pop_front();
                    compare_field("scl_low", want.scl_low, got.scl_low);
                    compare_field("sda_low", want.sda_low, got.sda_low);
                    compare_field("read_byte", want.read_byte, got.read_byte);
                    compare_field("read_valid", want.read_valid, got.read_valid);
                    compare_field("need_byte", want.need_byte, got.need_byte);
                    compare_field("done_res", want.done_res, got.done_res);
                    compare_field("nack", want.nack, got.nack);
                    compare_field("busy_res", want.busy_res, got.busy_res);
                end
            end
            if (long_hold_left != 0) begin
                m_axis_tready <= 1'b0;
            end else begin
                if (recv_gap == 0 && !quiet && $urandom_range(0, 9) == 0)
                    recv_gap = $urandom_range(1, 18);
                if (recv_gap != 0) begin
                    recv_gap--;
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin : sequence_main
        int drain_cycles;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: fastest timing, highest address, any high poll is a nack
        program_regs(8'd254, 16'd0, 16'd0, 8'd0);
        push_item(FUNC_NOP, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        push_item(FUNC_WRBYTE, 1'b0, 8'h00, 8'h00, 8'h55, 1'b0);
        push_item(FUNC_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 1'b1);
        // write of count zero leaves the bus without stop
        push_start(1'b0, 8'h00, 8'd0);
        finish_transfer(NO_FAIL, 1'b0, 1'b0);
        // read of count zero right after it: address ack then straight to stop
        push_start(1'b1, 8'hFF, 8'd0);
        push_item(FUNC_START, 1'b0, 8'h12, 8'd4, 8'h00, 1'b0);
        push_item(FUNC_WRBYTE, 1'b0, 8'h00, 8'h00, 8'hFF, 1'b1);
        push_item(FUNC_NOP, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0);
        finish_transfer(NO_FAIL, 1'b0, 1'b0);
        // data bytes at both extremes
        push_start(1'b0, 8'hA5, 8'd2);
        finish_transfer(NO_FAIL, 1'b1, 1'b0);
        // single byte read: its only byte gets the nack
        push_start(1'b1, 8'h5A, 8'd1);
        finish_transfer(NO_FAIL, 1'b0, 1'b0);
        // missing ack on the address of a long write
        push_start(1'b0, 8'h3C, 8'd255);
        finish_transfer(0, 1'b0, 1'b0);
        // missing ack on the register number of a read
        push_start(1'b1, 8'hC3, 8'd200);
        finish_transfer(1, 1'b0, 1'b0);
        // missing ack on the read address after the repeated start
        push_start(1'b1, 8'h0F, 8'd3);
        finish_transfer(2, 1'b0, 1'b0);

        // random part over several timing and poll settings
        run_phase(8'd254, 16'd0, 16'd0, 8'd0, 150, 1'b0);
        run_phase(8'($urandom_range(0, 254)), 16'd1, 16'd0, 8'd3, 200, 1'b0);
        run_phase(8'd0, 16'd0, 16'd2, 8'd255, 200, 1'b0);
        run_phase(8'($urandom_range(0, 254)), 16'd3, 16'd1, 8'd7, 200, 1'b1);
        wait_drained();
        quiet = 1'b1;
        run_phase(8'($urandom_range(0, 254)), 16'd0, 16'd0, 8'd2, 200, 1'b0);

        // longest release time while idle: every item here is dropped
        program_regs(8'($urandom_range(0, 254)), 16'd0, 16'hFFFF, 8'd255);
        repeat (4) push_noise();
        repeat (4) push_item(FUNC_TICK, $urandom, $urandom, $urandom, $urandom, $urandom);

        // longest step time: the wait after the first scl release counts down from the top
        program_regs(8'($urandom_range(0, 254)), 16'hFFFF, 16'd1, RST_POLL_LIM);
        push_start(1'b1, $urandom, $urandom);
        repeat (200) push_item(FUNC_TICK, $urandom, $urandom, $urandom, $urandom, $urandom);

        drain_cycles = 0;
        while ((pending_q.size() != 0 || s_axis_tvalid || expected_status_q.size() != 0) &&
               drain_cycles < 5000) begin
            @(negedge i_clk);
            drain_cycles++;
        end
        repeat (4) @(posedge i_clk);
        if (expected_status_q.size() != 0 || pending_q.size() != 0) begin
            $error("%0d result items never arrived", expected_status_q.size() + pending_q.size());
            mismatch_cnt++;
        end

        $display("covered %0d transfers (%0d reads), %0d bytes read, %0d clean and %0d nack endings",
                 transfers, reads_started, bytes_read, clean_ends, nack_ends);
        $display("%0d working items, %0d result items checked", work_items, results_seen);
        if (mismatch_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // hang guard
    initial begin
        #(20_000_000);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
rtl/i2cram_pkg.sv
rtl/i2cram_engine.sv
rtl/i2c_register_access_master.sv
dv/i2c_register_access_master_tb.sv
